>>> rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants of the bitmap sort engine: item codes, result
// status codes, default sizes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int WORD_BITS_DEF  = 32;

	localparam int FUNC_W   = 2;
	localparam int VALUE_W  = 17;
	localparam int STATUS_W = 3;
	localparam int RESULT_W = 16;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FETCH  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DELIVERED = 3'd1,
		ST_DONE      = 3'd2,
		ST_RANGE     = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	typedef struct packed {
		logic    accept;
		logic    ins_rd;
		logic    ins_wr;
		logic    scan_start;
		logic    scan_step;
		logic    clr_start;
		logic    clr_step;
		logic    rsp_load;
		status_t rsp_status;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic cursor_end;
		logic scan_hit;
		logic scan_last;
		logic clr_last;
		logic rsp_free;
	} sts_t;

endpackage

>>> rtl/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Controller of the bitmap sort engine: takes one transaction at a time,
// sequences the insert read-modify-write, the fetch word scan and the clear
// sweep, and hands the result status to the output register.
// ----------------------------------------------------------------------------
module bse_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [bse_pkg::FUNC_W-1:0] func,
	input  bse_pkg::sts_t              sts,
	output bse_pkg::cmd_t              cmd
);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_INS_WR = 6'b000100,
		S_SCAN   = 6'b001000,
		S_CLEAR  = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t           state_q, state_nxt;
	bse_pkg::status_t status_q, status_nxt;

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		status_nxt = status_q;
		req_stall  = (state_q != S_IDLE);
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					unique case (func)
						bse_pkg::FN_INSERT: begin
							if (sts.in_range) begin
								cmd.ins_rd = 1'b1;
								state_nxt  = S_INS_WR;
							end else begin
								status_nxt = bse_pkg::ST_RANGE;
								state_nxt  = S_RESP;
							end
						end
						bse_pkg::FN_FETCH: begin
							if (sts.cursor_end) begin
								status_nxt = bse_pkg::ST_DONE;
								state_nxt  = S_RESP;
							end else begin
								cmd.scan_start = 1'b1;
								state_nxt      = S_SCAN;
							end
						end
						bse_pkg::FN_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_nxt     = S_CLEAR;
						end
						default: begin
							status_nxt = bse_pkg::ST_RANGE;
							state_nxt  = S_RESP;
						end
					endcase
				end
			end
			S_INS_WR: begin
				cmd.ins_wr = 1'b1;
				status_nxt = bse_pkg::ST_INSERTED;
				state_nxt  = S_RESP;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit) begin
					status_nxt = bse_pkg::ST_DELIVERED;
					state_nxt  = S_RESP;
				end else if (sts.scan_last) begin
					status_nxt = bse_pkg::ST_DONE;
					state_nxt  = S_RESP;
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					status_nxt = bse_pkg::ST_CLEARED;
					state_nxt  = S_RESP;
				end
			end
			S_RESP: begin
				cmd.rsp_load = sts.rsp_free;
				if (sts.rsp_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
		cmd.rsp_status = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			status_q <= bse_pkg::ST_INSERTED;
		end else begin
			state_q  <= state_nxt;
			status_q <= status_nxt;
		end
	end

endmodule

>>> rtl/bse_dp.sv
// ----------------------------------------------------------------------------
// bse_dp
// Datapath of the bitmap sort engine: presence bitmap memory, scan cursor,
// word scan counter with lowest-set-bit search, clear sweep counter and the
// registered result stage.
// ----------------------------------------------------------------------------
module bse_dp #(
	parameter int VALUE_BITS = bse_pkg::VALUE_BITS_DEF,
	parameter int WORD_BITS  = bse_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bse_pkg::VALUE_W-1:0]  value,
	input  bse_pkg::cmd_t                cmd,
	output bse_pkg::sts_t                sts,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [bse_pkg::STATUS_W-1:0] status,
	output logic [bse_pkg::RESULT_W-1:0] sorted_value
);

	localparam int WL        = $clog2(WORD_BITS);
	localparam int ADDR_BITS = (VALUE_BITS > WL) ? (VALUE_BITS - WL) : 1;
	localparam int WORDS     = 2 ** ADDR_BITS;
	localparam int FOUND_W   = ADDR_BITS + WL;
	localparam int CUR_W     = VALUE_BITS + 1;

	logic [WORD_BITS-1:0] mem [WORDS];

	logic [CUR_W-1:0]     cursor_q;
	logic [ADDR_BITS:0]   scan_addr_q;
	logic                 first_q;
	logic [ADDR_BITS-1:0] rd_addr_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic [WL-1:0]        ins_bit_q;
	logic [ADDR_BITS-1:0] clr_cnt_q;
	logic [FOUND_W-1:0]   found_q;
	logic                 rsp_valid_q;
	logic [bse_pkg::STATUS_W-1:0] status_q;
	logic [bse_pkg::RESULT_W-1:0] sorted_q;

	logic [ADDR_BITS-1:0] cur_word;
	logic [ADDR_BITS-1:0] val_word;
	logic [WORD_BITS-1:0] masked;
	logic [WL-1:0]        ffs;
	logic [FOUND_W-1:0]   found;
	logic                 rd_en;
	logic [ADDR_BITS-1:0] rd_addr;
	logic                 wr_en;
	logic [ADDR_BITS-1:0] wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 scan_more;

	assign cur_word = ADDR_BITS'(cursor_q >> WL);
	assign val_word = ADDR_BITS'(value >> WL);

	assign masked = first_q ? (rdata_q & ({WORD_BITS{1'b1}} << cursor_q[WL-1:0])) : rdata_q;

	// lowest set bit of the masked word
	always_comb begin
		ffs = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (masked[i]) begin
				ffs = WL'(i);
			end
		end
	end

	assign found = {rd_addr_q, ffs};

	assign sts.in_range   = ((value >> VALUE_BITS) == '0);
	assign sts.cursor_end = cursor_q[VALUE_BITS];
	assign sts.scan_hit   = |masked;
	assign sts.scan_last  = (scan_addr_q == (ADDR_BITS + 1)'(WORDS));
	assign sts.clr_last   = (clr_cnt_q == {ADDR_BITS{1'b1}});
	assign sts.rsp_free   = !rsp_valid_q || !rsp_stall;

	assign scan_more = cmd.scan_step && !sts.scan_hit && !sts.scan_last;

	always_comb begin
		rd_en   = cmd.ins_rd || cmd.scan_start || scan_more;
		rd_addr = scan_addr_q[ADDR_BITS-1:0];
		if (cmd.ins_rd) begin
			rd_addr = val_word;
		end else if (cmd.scan_start) begin
			rd_addr = cur_word;
		end
		wr_en   = cmd.ins_wr || cmd.clr_step;
		wr_addr = cmd.clr_step ? clr_cnt_q : rd_addr_q;
		wr_data = cmd.clr_step ? '0 : (rdata_q | (WORD_BITS'(1) << ins_bit_q));
	end

	// bitmap memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q   <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ins_bit_q <= value[WL-1:0];
		end
		if (cmd.scan_step && sts.scan_hit) begin
			found_q <= found;
		end
		if (cmd.rsp_load) begin
			status_q <= cmd.rsp_status;
			sorted_q <= (cmd.rsp_status == bse_pkg::ST_DELIVERED) ?
			            bse_pkg::RESULT_W'(found_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			scan_addr_q <= '0;
			first_q     <= 1'b0;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_start) begin
				cursor_q  <= '0;
				clr_cnt_q <= '0;
			end else if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.scan_start) begin
				scan_addr_q <= (ADDR_BITS + 1)'(cur_word) + 1'b1;
				first_q     <= 1'b1;
			end else if (cmd.scan_step) begin
				if (sts.scan_hit) begin
					cursor_q <= CUR_W'(found) + CUR_W'(1);
				end else if (sts.scan_last) begin
					cursor_q <= CUR_W'(1) << VALUE_BITS;
				end else begin
					scan_addr_q <= scan_addr_q + 1'b1;
					first_q     <= 1'b0;
				end
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign sorted_value = sorted_q;

endmodule

>>> rtl/bitmap_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// bitmap_sort_engine_unit
// Bit-vector sort of distinct integers: insert sets a presence bit, fetch
// returns the next set value in ascending order, clear empties the bitmap.
// ----------------------------------------------------------------------------
// insert: reads the bitmap word, then writes it back with the bit set;
//   an out-of-range value skips both, and no new transaction is taken until the
//   result is loaded; fetch scans words from the cursor, one word per cycle
//   through the single read port; clear zeroes the bitmap one word a cycle
// reset: cursor zeroed at once, then a sweep
//   zeroes the bitmap while req_stall stays high
module bitmap_sort_engine_unit #(
	parameter int VALUE_BITS = bse_pkg::VALUE_BITS_DEF,
	parameter int WORD_BITS  = bse_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [bse_pkg::FUNC_W-1:0]   func,
	input  logic [bse_pkg::VALUE_W-1:0]  value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [bse_pkg::STATUS_W-1:0] status,
	output logic [bse_pkg::RESULT_W-1:0] sorted_value
);

	bse_pkg::cmd_t cmd;
	bse_pkg::sts_t sts;

	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.sts       (sts),
		.cmd       (cmd)
	);

	bse_dp #(
		.VALUE_BITS (VALUE_BITS),
		.WORD_BITS  (WORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.cmd          (cmd),
		.sts          (sts),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.sorted_value (sorted_value)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_sort_engine_unit. Inserts, fetches, clears
// and invalid codes are queued by an initial block and driven one transaction
// at a time. A bit-accurate predictor of the bitmap and scan cursor computes
// the status and sorted value of each accepted transaction; a monitor compares
// every returned transaction with the oldest prediction. Sender gaps and
// receiver stalls change over the run, and one long receiver hold-off lets the
// engine fill up and stall its input.
// ----------------------------------------------------------------------------
module tb;
	import bse_pkg::*;

	localparam int VB         = VALUE_BITS_DEF;
	localparam int WB         = WORD_BITS_DEF;
	localparam int NUM_VALUES = 1 << VB;
	localparam int NUM_WORDS  = NUM_VALUES / WB;
	localparam int RANDOM_CMDS = 1150;
	localparam int HOLD_CYCLES = 400;

	localparam logic [FUNC_W-1:0] FN_BAD = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0]  f;
		logic [VALUE_W-1:0] v;
	} sort_cmd_t;

	typedef struct {
		status_t             st;
		logic [RESULT_W-1:0] val;
	} sort_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [VALUE_W-1:0] value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [RESULT_W-1:0] sorted_value;

	sort_cmd_t sort_cmd_q[$];
	sort_rsp_t sort_expect_q[$];

	logic [WB-1:0] bitmap_words [NUM_WORDS];
	logic [VALUE_W-1:0] scan_pos;

	int accepted_cnt = 0;
	int returned_cnt = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int fail_cnt = 0;

	bitmap_sort_engine_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.sorted_value(sorted_value)
	);

	always #5 clk = ~clk;

	function automatic void wipe_bitmap();
		foreach (bitmap_words[i]) bitmap_words[i] = '0;
		scan_pos = '0;
	endfunction

	function automatic sort_rsp_t predict_sort(input logic [FUNC_W-1:0] f,
			input logic [VALUE_W-1:0] v);
		sort_rsp_t r;
		int w;
		int b;
		logic [WB-1:0] word;
		bit hit;
		r.st = ST_RANGE;
		r.val = '0;
		hit = 1'b0;
		w = 0;
		b = 0;
		case (f)
			FN_INSERT: begin
				if (v < NUM_VALUES) begin
					bitmap_words[v / WB][v % WB] = 1'b1;
					r.st = ST_INSERTED;
				end
			end
			FN_FETCH: begin
				if (scan_pos < NUM_VALUES) begin
					w = scan_pos / WB;
					b = scan_pos % WB;
					while (w < NUM_WORDS && !hit) begin
						word = bitmap_words[w] & ({WB{1'b1}} << b);
						if (word != '0) begin
							for (int k = WB - 1; k >= 0; k--)
								if (word[k]) b = k;
							hit = 1'b1;
						end else begin
							w++;
							b = 0;
						end
					end
				end
				if (hit) begin
					r.st = ST_DELIVERED;
					r.val = RESULT_W'(w * WB + b);
					scan_pos = VALUE_W'(w * WB + b + 1);
				end else begin
					r.st = ST_DONE;
					scan_pos = VALUE_W'(NUM_VALUES);
				end
			end
			FN_CLEAR: begin
				wipe_bitmap();
				r.st = ST_CLEARED;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int idle_pct(input bit recv);
		int phase;
		phase = (accepted_cnt / 100) % 4;
		if (phase == 3) return 12;
		if (recv && phase == 2) return 58;
		if (!recv && phase == 1) return 58;
		return 0;
	endfunction

	task automatic add_cmd(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
		sort_cmd_t c;
		c.f = f;
		c.v = v;
		sort_cmd_q.push_back(c);
	endtask

	function automatic logic [VALUE_W-1:0] any_value();
		return VALUE_W'($urandom_range(0, 2 ** VALUE_W - 1));
	endfunction

	// clear, a batch of inserts, then fetches mostly until exhaustion
	task automatic add_sort_run();
		int n;
		int n_fetch;
		int base;
		int r;
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] kept[$];
		add_cmd(FN_CLEAR, any_value());
		n = $urandom_range(3, 24);
		base = $urandom_range(0, NUM_VALUES - 512);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				v = VALUE_W'($urandom_range(NUM_VALUES, 2 ** VALUE_W - 1));
			else if (r < 18 && kept.size() != 0)
				v = kept[$urandom_range(0, kept.size() - 1)];
			else if (r < 21)
				v = (r == 19) ? '0 : VALUE_W'(NUM_VALUES - 1);
			else if (r < 33)
				v = VALUE_W'($urandom_range(0, NUM_VALUES - 1));
			else
				v = VALUE_W'(base + $urandom_range(0, 511));
			kept.push_back(v);
			add_cmd(FN_INSERT, v);
		end
		if ($urandom_range(0, 99) < 20)
			n_fetch = $urandom_range(1, n);
		else
			n_fetch = n + $urandom_range(1, 3);
		for (int i = 0; i < n_fetch; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				add_cmd(FN_INSERT, VALUE_W'(base + $urandom_range(0, 511)));
			else if (r < 15)
				add_cmd(FN_BAD, any_value());
			else if (r < 18)
				add_cmd(FN_INSERT, any_value());
			add_cmd(FN_FETCH, any_value());
		end
	endtask

	always @(posedge clk) begin : drive_proc
		sort_rsp_t e;
		sort_cmd_t c;
		int gap;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				e = predict_sort(func, value);
				sort_expect_q.push_back(e);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!req_valid || !req_stall) begin
				gap = (hold_left != 0) ? 0 : idle_pct(1'b0);
				if (sort_cmd_q.size() != 0 && $urandom_range(0, 99) >= gap) begin
					c = sort_cmd_q.pop_front();
					req_valid <= 1'b1;
					func <= c.f;
					value <= c.v;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : stall_proc
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && returned_cnt >= 300) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
		end
	end

	always @(posedge clk) begin : check_proc
		sort_rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			returned_cnt <= returned_cnt + 1;
			if (sort_expect_q.size() == 0) begin
				$display("%0t: unexpected transaction status %0d sorted_value %0d",
					$time, status, sorted_value);
				fail_cnt++;
			end else begin
				e = sort_expect_q.pop_front();
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					fail_cnt++;
				end
				if (sorted_value !== e.val) begin
					$display("%0t: sorted_value expected %0d actual %0d",
						$time, e.val, sorted_value);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("[bitmap_sort_engine_unit] ERROR");
		$finish;
	end

	initial begin
		wipe_bitmap();
		// extremes, out of range, duplicates, exhaustion
		add_cmd(FN_INSERT, 17'd0);
		add_cmd(FN_INSERT, VALUE_W'(NUM_VALUES - 1));
		add_cmd(FN_INSERT, VALUE_W'(NUM_VALUES));
		add_cmd(FN_INSERT, '1);
		add_cmd(FN_INSERT, 17'd0);
		add_cmd(FN_FETCH, '1);
		add_cmd(FN_FETCH, 17'd0);
		add_cmd(FN_FETCH, any_value());
		add_cmd(FN_FETCH, any_value());
		add_cmd(FN_BAD, '1);
		add_cmd(FN_CLEAR, '1);
		// word boundaries and insert below the cursor
		add_cmd(FN_INSERT, 17'd200);
		add_cmd(FN_INSERT, 17'd31);
		add_cmd(FN_INSERT, 17'd32);
		add_cmd(FN_FETCH, any_value());
		add_cmd(FN_INSERT, 17'd5);
		add_cmd(FN_FETCH, any_value());
		add_cmd(FN_FETCH, any_value());
		add_cmd(FN_FETCH, any_value());
		add_cmd(FN_CLEAR, 17'd0);
		while (sort_cmd_q.size() < 20 + RANDOM_CMDS) begin
			if ($urandom_range(0, 99) < 5)
				add_cmd(FN_BAD + FUNC_W'($urandom_range(0, 3)), any_value());
			else
				add_sort_run();
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (sort_cmd_q.size() != 0 || req_valid || sort_expect_q.size() != 0)
			@(negedge clk);
		repeat (2100) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("[bitmap_sort_engine_unit] OK");
		end else begin
			$display("[bitmap_sort_engine_unit] ERROR");
		end
		$finish;
	end

endmodule

>>> bitmap_sort_engine_unit.f
rtl/bse_pkg.sv
rtl/bse_ctrl.sv
rtl/bse_dp.sv
rtl/bitmap_sort_engine_unit.sv
tb/tb.sv
